@@ hw/rtl/bpm_pkg.sv @@
// Package: shared types, constants and register indexes for the burst position block.
package bpm_pkg;

  localparam int unsigned BASELINE_LEN_DEF = 50;
  localparam int unsigned WINDOW_LEN_DEF   = 250;

  localparam int unsigned SMP_W   = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SCALE_W = 25;
  localparam int unsigned OFF_W   = 25;
  localparam int unsigned CFG_W   = 25;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned TOT_W   = 26;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned DIV_N_W = 51;
  localparam int unsigned DIV_D_W = 26;

  localparam logic [GAIN_W-1:0]  GAIN_UNITY = 16'd32767;
  localparam logic [CNT_W-1:0]   COUNT_MAX  = 16'hFFFF;
  localparam logic [ADDR_W-1:0] REG_GAIN_A   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_GAIN_B   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_GAIN_C   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_SCALE_X  = 3'd4;
  localparam logic [ADDR_W-1:0] REG_SCALE_Y  = 3'd5;
  localparam logic [ADDR_W-1:0] REG_OFFSET_X = 3'd6;
  localparam logic [ADDR_W-1:0] REG_OFFSET_Y = 3'd7;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_a;
    logic signed [SMP_W-1:0] sample_b;
    logic signed [SMP_W-1:0] sample_c;
    logic signed [SMP_W-1:0] sample_d;
    logic                    last_sample;
  } in_t;

  typedef struct packed {
    logic [MAG_W-1:0]        mag_a;
    logic [MAG_W-1:0]        mag_b;
    logic [MAG_W-1:0]        mag_c;
    logic [MAG_W-1:0]        mag_d;
    logic [TOT_W-1:0]        mag_total;
    logic signed [POS_W-1:0] x_pos_nm;
    logic signed [POS_W-1:0] y_pos_nm;
    logic                    short_burst;
  } out_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic       scl_en;
    logic       acc_en;
    logic       div_start;
    logic       mag_mul;
    logic [1:0] chan;
    logic       pos_y;
    logic       mag_store;
    logic       pos_prod;
    logic       pos_store;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } sts_t;

endpackage

@@ hw/rtl/bpm_burst_position.sv @@
// Top level: beam position from a burst of four-channel ADC samples.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   in_data_i (bpm_pkg::in_t)
//   out      source     out_valid_o/out_ready_i out_data_o (bpm_pkg::out_t)
//   cfg      sink       cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// Each sample is accepted, gain multiplied, divided by 32767 and accumulated.
// The last sample of a burst then computes four magnitudes (reciprocal multiply, store),
// x and y (product, start, 51 steps of the bit-serial divider, store) and loads the
// result.
// A waiting result stalls only the next last sample; other samples keep flowing.
// Reset restores the gains, scales and offsets and clears the burst sums.
module bpm_burst_position #(
  parameter int unsigned BASELINE_LEN = bpm_pkg::BASELINE_LEN_DEF,
  parameter int unsigned WINDOW_LEN   = bpm_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bpm_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bpm_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [bpm_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [bpm_pkg::CFG_W-1:0]  cfg_wdata_i
);

  bpm_pkg::cmd_t cmd;
  bpm_pkg::sts_t sts;

  bpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpm_datapath #(
    .BASELINE_LEN (BASELINE_LEN),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/bpm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module bpm_div #(
  parameter int unsigned N_W = bpm_pkg::DIV_N_W,
  parameter int unsigned D_W = bpm_pkg::DIV_D_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int unsigned C_W = $clog2(N_W + 1);

  logic [N_W-1:0] quo_q, quo_d;
  logic [D_W-1:0] rem_q, rem_d;
  logic [D_W-1:0] dvs_q, dvs_d;
  logic [C_W-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [D_W:0]   rem_sh;
  logic [D_W:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_q[N_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = C_W'(N_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[D_W-1:0];
        quo_d = {quo_q[N_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[D_W-1:0];
        quo_d = {quo_q[N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - C_W'(1);
      if (cnt_q == C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hw/rtl/bpm_datapath.sv @@
// Datapath: config registers, scaling, baseline and deviation sums, result math.
module bpm_datapath #(
  parameter int unsigned BASELINE_LEN = bpm_pkg::BASELINE_LEN_DEF,
  parameter int unsigned WINDOW_LEN   = bpm_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpm_pkg::ADDR_W-1:0]  cfg_addr_i,
  input  logic [bpm_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  bpm_pkg::in_t                in_data_i,
  input  bpm_pkg::cmd_t               cmd_i,
  output bpm_pkg::sts_t               sts_o,
  output bpm_pkg::out_t               out_data_o
);

  localparam int unsigned BASE_W = 17 + $clog2(BASELINE_LEN);
  localparam int unsigned DIFF_W = 18 + $clog2(BASELINE_LEN);
  localparam int unsigned DEV_W  = 17 + $clog2(BASELINE_LEN) + $clog2(WINDOW_LEN + 1);
  localparam int unsigned PROD_W = bpm_pkg::SMP_W + bpm_pkg::GAIN_W + 1;
  localparam int unsigned ABS_W  = PROD_W - 1;
  localparam int unsigned SCL_W  = 19;
  localparam int unsigned Q_W    = bpm_pkg::DIV_N_W + 2;
  localparam int unsigned BL_L   = $clog2(BASELINE_LEN);
  localparam int unsigned RN_W   = bpm_pkg::MAG_W + BL_L;
  localparam int unsigned RM_W   = RN_W + 1;
  localparam int unsigned RP_W   = RN_W + RM_W;
  localparam logic [RM_W-1:0] RCP_M =
    RM_W'(((64'd1 << (RN_W + BL_L)) + 64'(BASELINE_LEN - 1)) / 64'(BASELINE_LEN));
  localparam logic [63:0] MAG_LIM = 64'(BASELINE_LEN) << bpm_pkg::MAG_W;
  localparam logic signed [DIFF_W-1:0] BL_S = DIFF_W'(BASELINE_LEN);
  localparam logic [bpm_pkg::CNT_W-1:0] BL_CNT  = bpm_pkg::CNT_W'(BASELINE_LEN);
  localparam logic [bpm_pkg::CNT_W-1:0] END_CNT =
    bpm_pkg::CNT_W'(BASELINE_LEN + WINDOW_LEN);

  logic [bpm_pkg::GAIN_W-1:0]         gain_q [4];
  logic [bpm_pkg::SCALE_W-1:0]        scale_x_q, scale_y_q;
  logic signed [bpm_pkg::OFF_W-1:0]   off_x_q, off_y_q;

  bpm_pkg::in_t                       in_q;
  logic signed [PROD_W-1:0]           prod_q [4];
  logic signed [bpm_pkg::SMP_W-1:0]   scl_q [4];
  logic signed [BASE_W-1:0]           base_q [4];
  logic [DEV_W-1:0]                   dev_q [4];
  logic [bpm_pkg::CNT_W-1:0]          cnt_q;
  logic [bpm_pkg::MAG_W-1:0]          mag_q [4];
  logic [RP_W-1:0]                    mprod_q;
  logic                               movf_q;
  logic [bpm_pkg::DIV_N_W-1:0]        pprod_q;
  logic                               psign_q;
  logic signed [bpm_pkg::POS_W-1:0]   posx_q, posy_q;
  bpm_pkg::out_t                      out_q;

  logic signed [bpm_pkg::SMP_W-1:0]   smp [4];
  logic signed [bpm_pkg::SMP_W-1:0]   scl_d [4];
  logic [DEV_W-1:0]                   dev_sel;
  logic [bpm_pkg::TOT_W-1:0]          total;
  logic [bpm_pkg::TOT_W-1:0]          sum_ad, sum_bc, sum_ab, sum_cd;
  logic signed [bpm_pkg::TOT_W:0]     dif;
  logic [bpm_pkg::TOT_W-1:0]          dif_abs;
  logic [bpm_pkg::SCALE_W-1:0]        kscale;
  logic signed [bpm_pkg::OFF_W-1:0]   koff;
  logic [bpm_pkg::DIV_N_W-1:0]        div_dividend;
  logic [bpm_pkg::DIV_D_W-1:0]        div_divisor;
  logic                               div_done;
  logic [bpm_pkg::DIV_N_W-1:0]        div_quo;
  logic signed [Q_W-1:0]              q_s;
  logic signed [Q_W-1:0]              pos_v;
  logic signed [bpm_pkg::POS_W-1:0]   pos_sat;
  logic [bpm_pkg::MAG_W-1:0]          mag_sat;

  assign smp[0] = in_q.sample_a;
  assign smp[1] = in_q.sample_b;
  assign smp[2] = in_q.sample_c;
  assign smp[3] = in_q.sample_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) gain_q[i] <= bpm_pkg::GAIN_UNITY;
      scale_x_q <= bpm_pkg::SCALE_W'(1);
      scale_y_q <= bpm_pkg::SCALE_W'(1);
      off_x_q   <= '0;
      off_y_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bpm_pkg::REG_GAIN_A:   gain_q[0] <= cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
        bpm_pkg::REG_GAIN_B:   gain_q[1] <= cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
        bpm_pkg::REG_GAIN_C:   gain_q[2] <= cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
        bpm_pkg::REG_GAIN_D:   gain_q[3] <= cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
        bpm_pkg::REG_SCALE_X:  scale_x_q <= cfg_wdata_i[bpm_pkg::SCALE_W-1:0];
        bpm_pkg::REG_SCALE_Y:  scale_y_q <= cfg_wdata_i[bpm_pkg::SCALE_W-1:0];
        bpm_pkg::REG_OFFSET_X: off_x_q   <= $signed(cfg_wdata_i[bpm_pkg::OFF_W-1:0]);
        bpm_pkg::REG_OFFSET_Y: off_y_q   <= $signed(cfg_wdata_i[bpm_pkg::OFF_W-1:0]);
        default: ;
      endcase
    end
  end

  // divide by 32767: x = q1*32767 + (lo + q1), then fix up by at most three
  always_comb begin
    logic [ABS_W-1:0]   ab;
    logic [ABS_W-16:0]  q1;
    logic [ABS_W-14:0]  r;
    logic [SCL_W-1:0]   q;
    logic signed [SCL_W-1:0] v;
    for (int i = 0; i < 4; i++) begin
      ab = prod_q[i][PROD_W-1] ? ABS_W'(-prod_q[i]) : ABS_W'(prod_q[i]);
      q1 = ab[ABS_W-1:15];
      r  = (ABS_W-13)'(ab[14:0]) + (ABS_W-13)'(q1);
      q  = SCL_W'(q1)
         + SCL_W'(r >= (ABS_W-13)'(32767))
         + SCL_W'(r >= (ABS_W-13)'(65534))
         + SCL_W'(r >= (ABS_W-13)'(98301));
      v  = prod_q[i][PROD_W-1] ? -$signed(q) : $signed(q);
      if (v > SCL_W'(32767))       scl_d[i] = 16'sh7FFF;
      else if (v < -SCL_W'(32768)) scl_d[i] = 16'sh8000;
      else                         scl_d[i] = v[bpm_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    if (cmd_i.mul_en) begin
      prod_q[0] <= PROD_W'(smp[0]) * $signed({1'b0, gain_q[0]});
      prod_q[1] <= PROD_W'(smp[1]) * $signed({1'b0, gain_q[1]});
      prod_q[2] <= PROD_W'(smp[2]) * $signed({1'b0, gain_q[2]});
      prod_q[3] <= PROD_W'(smp[3]) * $signed({1'b0, gain_q[3]});
    end
    if (cmd_i.scl_en) begin
      for (int i = 0; i < 4; i++) scl_q[i] <= scl_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [DIFF_W-1:0] d;
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < 4; i++) begin
        base_q[i] <= '0;
        dev_q[i]  <= '0;
      end
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      for (int i = 0; i < 4; i++) begin
        base_q[i] <= '0;
        dev_q[i]  <= '0;
      end
    end else if (cmd_i.acc_en) begin
      for (int i = 0; i < 4; i++) begin
        d = BL_S * DIFF_W'(scl_q[i]) - DIFF_W'(base_q[i]);
        if (cnt_q < BL_CNT) begin
          base_q[i] <= base_q[i] + BASE_W'(scl_q[i]);
        end else if (cnt_q < END_CNT) begin
          dev_q[i] <= dev_q[i] + (d[DIFF_W-1] ? DEV_W'(-d) : DEV_W'(d));
        end
      end
      if (cnt_q != bpm_pkg::COUNT_MAX) cnt_q <= cnt_q + bpm_pkg::CNT_W'(1);
    end
  end

  // divide by BASELINE_LEN through a reciprocal multiply, exact below the saturation limit
  assign dev_sel = dev_q[cmd_i.chan];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag_mul) begin
      mprod_q <= RP_W'(RN_W'(dev_sel)) * RP_W'(RCP_M);
      movf_q  <= (64'(dev_sel) >= MAG_LIM);
    end
  end

  assign mag_sat = movf_q ? {bpm_pkg::MAG_W{1'b1}} : mprod_q[RN_W + BL_L +: bpm_pkg::MAG_W];

  assign total  = bpm_pkg::TOT_W'(mag_q[0]) + bpm_pkg::TOT_W'(mag_q[1])
                + bpm_pkg::TOT_W'(mag_q[2]) + bpm_pkg::TOT_W'(mag_q[3]);
  assign sum_ad = bpm_pkg::TOT_W'(mag_q[0]) + bpm_pkg::TOT_W'(mag_q[3]);
  assign sum_bc = bpm_pkg::TOT_W'(mag_q[1]) + bpm_pkg::TOT_W'(mag_q[2]);
  assign sum_ab = bpm_pkg::TOT_W'(mag_q[0]) + bpm_pkg::TOT_W'(mag_q[1]);
  assign sum_cd = bpm_pkg::TOT_W'(mag_q[2]) + bpm_pkg::TOT_W'(mag_q[3]);
  assign dif    = cmd_i.pos_y ? $signed({1'b0, sum_ab}) - $signed({1'b0, sum_cd})
                              : $signed({1'b0, sum_ad}) - $signed({1'b0, sum_bc});
  assign dif_abs = dif[bpm_pkg::TOT_W] ? bpm_pkg::TOT_W'(-dif) : bpm_pkg::TOT_W'(dif);
  assign kscale  = cmd_i.pos_y ? scale_y_q : scale_x_q;
  assign koff    = cmd_i.pos_y ? off_y_q : off_x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_prod) begin
      pprod_q <= bpm_pkg::DIV_N_W'(kscale) * bpm_pkg::DIV_N_W'(dif_abs);
      psign_q <= dif[bpm_pkg::TOT_W];
    end
  end

  assign div_dividend = pprod_q;
  assign div_divisor  = total;

  bpm_div #(
    .N_W (bpm_pkg::DIV_N_W),
    .D_W (bpm_pkg::DIV_D_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign q_s   = (total == '0) ? '0
               : (psign_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo}));
  assign pos_v = q_s - Q_W'(koff);

  always_comb begin
    if (pos_v > Q_W'(32'sh7FFFFFFF))       pos_sat = 32'sh7FFFFFFF;
    else if (pos_v < -Q_W'(33'sh80000000)) pos_sat = 32'sh80000000;
    else                                   pos_sat = pos_v[bpm_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag_store) mag_q[cmd_i.chan] <= mag_sat;
    if (cmd_i.pos_store) begin
      if (cmd_i.pos_y) posy_q <= pos_sat;
      else             posx_q <= pos_sat;
    end
    if (cmd_i.emit) begin
      out_q.mag_a       <= mag_q[0];
      out_q.mag_b       <= mag_q[1];
      out_q.mag_c       <= mag_q[2];
      out_q.mag_d       <= mag_q[3];
      out_q.mag_total   <= total;
      out_q.x_pos_nm    <= posx_q;
      out_q.y_pos_nm    <= posy_q;
      out_q.short_burst <= (cnt_q < END_CNT);
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.last     = in_q.last_sample;
  assign out_data_o     = out_q;

endmodule

@@ hw/rtl/bpm_ctrl.sv @@
// Controller: sequences each sample and the end-of-burst result computation.
module bpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bpm_pkg::sts_t sts_i,
  output bpm_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_SCL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_MSTART = 4'd4;
  localparam logic [3:0] S_MWAIT  = 4'd5;
  localparam logic [3:0] S_PPROD  = 4'd6;
  localparam logic [3:0] S_PSTART = 4'd7;
  localparam logic [3:0] S_PWAIT  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] chan_q, chan_d;
  logic       posy_q, posy_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d        = state_q;
    chan_d         = chan_q;
    posy_d         = posy_q;
    cmd_o          = '0;
    cmd_o.chan     = chan_q;
    cmd_o.pos_y    = posy_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SCL;
      end
      S_SCL: begin
        cmd_o.scl_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        chan_d       = '0;
        state_d      = sts_i.last ? S_MSTART : S_IDLE;
      end
      S_MSTART: begin
        cmd_o.mag_mul = 1'b1;
        state_d       = S_MWAIT;
      end
      S_MWAIT: begin
        cmd_o.mag_store = 1'b1;
        if (chan_q == 2'd3) begin
          posy_d  = 1'b0;
          state_d = S_PPROD;
        end else begin
          chan_d  = chan_q + 2'd1;
          state_d = S_MSTART;
        end
      end
      S_PPROD: begin
        cmd_o.pos_prod = 1'b1;
        state_d        = S_PSTART;
      end
      S_PSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_PWAIT;
      end
      S_PWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.pos_store = 1'b1;
          if (posy_q) begin
            state_d = S_EMIT;
          end else begin
            posy_d  = 1'b1;
            state_d = S_PPROD;
          end
        end
      end
      S_EMIT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ovalid_d = cmd_o.emit ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      chan_q   <= '0;
      posy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      chan_q   <= chan_d;
      posy_q   <= posy_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!ovalid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL))
    else $error("accepted beat not sequenced");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_PWAIT))
    else $error("divider finished outside a wait state");

endmodule

@@ tb/bpm_checker.sv @@
// Checker: predicts burst position results from observed beats and compares them.
module bpm_checker #(
  parameter int unsigned BASELINE_LEN = bpm_pkg::BASELINE_LEN_DEF,
  parameter int unsigned WINDOW_LEN   = bpm_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  bpm_pkg::in_t               in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  bpm_pkg::out_t              out_data_i,
  input  logic                       cfg_we_i,
  input  logic [bpm_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [bpm_pkg::CFG_W-1:0]  cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_o
);

  logic [bpm_pkg::GAIN_W-1:0]         gain [4];
  logic [bpm_pkg::SCALE_W-1:0]        scale_x, scale_y;
  logic signed [bpm_pkg::OFF_W-1:0]   offset_x, offset_y;
  int                                 sample_cnt;
  longint                             baseline [4];
  longint                             deviation [4];
  bpm_pkg::out_t                      position_q [$];

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  function automatic longint scaled(input logic signed [bpm_pkg::SMP_W-1:0] s,
                                    input logic [bpm_pkg::GAIN_W-1:0] g);
    longint p;
    p = longint'(s) * longint'(g) / longint'(bpm_pkg::GAIN_UNITY);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  function automatic logic [bpm_pkg::POS_W-1:0] pos_nm(input longint k, input longint diff,
                                                        input longint total,
                                                        input longint off);
    longint q;
    q = 0;
    if (total != 0) q = k * diff / total;
    q = q - off;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[bpm_pkg::POS_W-1:0];
  endfunction

  task automatic accept_sample(input bpm_pkg::in_t s);
    longint        smp [4];
    longint        mag [4];
    longint        d, total;
    bpm_pkg::out_t r;
    smp[0] = scaled(s.sample_a, gain[0]);
    smp[1] = scaled(s.sample_b, gain[1]);
    smp[2] = scaled(s.sample_c, gain[2]);
    smp[3] = scaled(s.sample_d, gain[3]);
    for (int i = 0; i < 4; i++) begin
      if (sample_cnt < BASELINE_LEN) begin
        baseline[i] += smp[i];
      end else if (sample_cnt < BASELINE_LEN + WINDOW_LEN) begin
        d = longint'(BASELINE_LEN) * smp[i] - baseline[i];
        deviation[i] += (d < 0) ? -d : d;
      end
    end
    if (sample_cnt < int'(bpm_pkg::COUNT_MAX)) sample_cnt++;
    if (s.last_sample) begin
      total = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = deviation[i] / BASELINE_LEN;
        if (mag[i] > 64'hFFFFFF) mag[i] = 64'hFFFFFF;
        total += mag[i];
      end
      r.mag_a       = mag[0][bpm_pkg::MAG_W-1:0];
      r.mag_b       = mag[1][bpm_pkg::MAG_W-1:0];
      r.mag_c       = mag[2][bpm_pkg::MAG_W-1:0];
      r.mag_d       = mag[3][bpm_pkg::MAG_W-1:0];
      r.mag_total   = total[bpm_pkg::TOT_W-1:0];
      r.x_pos_nm    = pos_nm(longint'(scale_x), (mag[0] + mag[3]) - (mag[1] + mag[2]),
                             total, longint'(offset_x));
      r.y_pos_nm    = pos_nm(longint'(scale_y), (mag[0] + mag[1]) - (mag[2] + mag[3]),
                             total, longint'(offset_y));
      r.short_burst = (sample_cnt < BASELINE_LEN + WINDOW_LEN);
      position_q.push_back(r);
      sample_cnt = 0;
      for (int i = 0; i < 4; i++) begin
        baseline[i]  = 0;
        deviation[i] = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bpm_pkg::out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        gain[i]      = bpm_pkg::GAIN_UNITY;
        baseline[i]  = 0;
        deviation[i] = 0;
      end
      scale_x      = 1;
      scale_y      = 1;
      offset_x     = '0;
      offset_y     = '0;
      sample_cnt   = 0;
      position_q.delete();
      fail_count_o = 0;
      results_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (position_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = position_q.pop_front();
          check_field("mag_a", want.mag_a, out_data_i.mag_a);
          check_field("mag_b", want.mag_b, out_data_i.mag_b);
          check_field("mag_c", want.mag_c, out_data_i.mag_c);
          check_field("mag_d", want.mag_d, out_data_i.mag_d);
          check_field("mag_total", want.mag_total, out_data_i.mag_total);
          check_field("x_pos_nm", want.x_pos_nm, out_data_i.x_pos_nm);
          check_field("y_pos_nm", want.y_pos_nm, out_data_i.y_pos_nm);
          check_field("short_burst", want.short_burst, out_data_i.short_burst);
        end
      end
      if (in_valid_i && in_ready_i) accept_sample(in_data_i);
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bpm_pkg::REG_GAIN_A:   gain[0]  = cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
          bpm_pkg::REG_GAIN_B:   gain[1]  = cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
          bpm_pkg::REG_GAIN_C:   gain[2]  = cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
          bpm_pkg::REG_GAIN_D:   gain[3]  = cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
          bpm_pkg::REG_SCALE_X:  scale_x  = cfg_wdata_i[bpm_pkg::SCALE_W-1:0];
          bpm_pkg::REG_SCALE_Y:  scale_y  = cfg_wdata_i[bpm_pkg::SCALE_W-1:0];
          bpm_pkg::REG_OFFSET_X: offset_x = cfg_wdata_i[bpm_pkg::OFF_W-1:0];
          bpm_pkg::REG_OFFSET_Y: offset_y = cfg_wdata_i[bpm_pkg::OFF_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = position_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, stimulus, configuration and verdict for the burst position block.
module testbench;

  localparam int LIMIT = 3000000;

  typedef enum int {K_RANDOM, K_CONSTANT, K_EXTREME, K_PULSE} kind_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  bpm_pkg::in_t               in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  bpm_pkg::out_t              out_data;
  logic                       cfg_we = 1'b0;
  logic [bpm_pkg::ADDR_W-1:0] cfg_addr = '0;
  logic [bpm_pkg::CFG_W-1:0]  cfg_wdata = '0;
  int                         fails, pending, results;
  int                         tx_idle, rx_idle;
  int                         hold_req, hold_seen, hold_left;
  int                         cycles, bursts, samples;
  logic signed [bpm_pkg::SMP_W-1:0] level [4];

  always #5 clk_i = ~clk_i;

  bpm_burst_position dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  bpm_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fails), .pending_o(pending), .results_o(results)
  );

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [bpm_pkg::SMP_W-1:0] pick_sample(input kind_e k,
                                                                   input int ch,
                                                                   input int idx);
    case (k)
      K_CONSTANT: return level[ch];
      K_EXTREME: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      K_PULSE: begin
        if (idx >= 50 && idx < 120) return level[ch] + $signed(16'($urandom_range(8191)));
        return level[ch] + $signed(16'($urandom_range(15))) - 16'sd8;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_burst(input int len, input kind_e k);
    for (int ch = 0; ch < 4; ch++) level[ch] = 16'($urandom_range(32767) - 16384);
    for (int i = 0; i < len; i++) begin
      while ($urandom_range(99) < tx_idle) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
      in_valid            <= 1'b1;
      in_data.sample_a    <= pick_sample(k, 0, i);
      in_data.sample_b    <= pick_sample(k, 1, i);
      in_data.sample_c    <= pick_sample(k, 2, i);
      in_data.sample_d    <= pick_sample(k, 3, i);
      in_data.last_sample <= (i == len - 1);
      do @(posedge clk_i); while (!in_ready);
      samples++;
      @(negedge clk_i);
    end
    in_valid <= 1'b0;
    bursts++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic program_regs(input int ga, input int gb, input int gc, input int gd,
                              input int sx, input int sy, input int ox, input int oy);
    int vals [8];
    vals = '{ga, gb, gc, gd, sx, sy, ox, oy};
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= bpm_pkg::ADDR_W'(i);
      cfg_wdata <= bpm_pkg::CFG_W'(vals[i]);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      2: return 32767;
      3: return 1;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(4))
      0: return 0;
      1: return 33554431;
      2: return 1;
      default: return $urandom_range(33554431);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(4))
      0: return -16777216;
      1: return 16777215;
      2: return 0;
      default: return int'($urandom_range(33554431)) - 16777216;
    endcase
  endfunction

  task automatic random_burst();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 18) len = 1;
    else len = $urandom_range(40, 1);
    send_burst(len, kind_e'($urandom_range(3)));
  endtask

  initial begin
    int phase_samples, phase_results;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    bursts = 0;
    samples = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_burst(1, K_EXTREME);
    send_burst(310, K_PULSE);
    program_regs(65535, 65535, 65535, 65535, 33554431, 33554431, -16777216, 16777215);
    send_burst(60, K_EXTREME);
    program_regs(0, 0, 0, 0, 0, 0, 16777215, -16777216);
    send_burst(20, K_RANDOM);
    program_regs(0, 1, 65535, 32767, 12345, 33554431, 16777215, -16777216);
    send_burst(51, K_PULSE);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 27 : (phase == 1) ? 70 : 0;
      rx_idle = (phase == 0) ? 70 : (phase == 1) ? 27 : 0;
      phase_samples = samples;
      phase_results = results;
      for (int setting = 0; setting < 4; setting++) begin
        program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                     pick_scale(), pick_scale(), pick_offset(), pick_offset());
        if (phase == 0 && setting == 1) begin
          hold_req++;
          repeat (6) send_burst($urandom_range(3, 1), K_RANDOM);
        end
        while (samples - phase_samples < (setting + 1) * 25 ||
               results - phase_results < (setting + 1) * 2) begin
          random_burst();
          if ($urandom_range(9) == 0) drain();
        end
      end
    end

    drain();
    repeat (400) @(negedge clk_i);
    $display("Covered %0d bursts and %0d samples, %0d results checked,", bursts, samples,
             results);
    $display("across gain, scale and offset settings including extremes and stalls.");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
